// ----- rtl/cld_pkg.sv -----
// shared constants, codes and types for the compacting list with delete
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cld_pkg;

    // list capacity and derived widths
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // fixed field widths of the request and result
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int WHERE_W  = 4;
    localparam int COUNT_W  = 5;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // one cycle's access to the entry store
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } mem_req_t;

endpackage

// ----- rtl/compacting_list_with_delete_core.sv -----
// top level of the compacting list: sequencer, entry store and result register
// depends on cld_pkg, cld_store, cld_ctrl
`timescale 1ns / 1ps

// An ordered list of up to 16 signed 32-bit values packed from index 0. Each
// request appends a value, removes the entry at a position, or finds the first
// entry equal to a value and removes it; every request gives one result with a
// status, the position touched and the new count. One request is worked at a
// time and in_ready is low while it runs. Append and refused requests go
// straight to the result state; remove at position p reads each entry after
// p and writes it one place lower; find-and-remove reads from index 0 until
// it meets a match at index i, then compacts from i as a remove does. The
// pace is set by the single read port of the entry store, which moves one
// entry per cycle. A finished result waits in the sequencer until the output
// register can take it; the next request is taken once it has moved there.

module compacting_list_with_delete_core
    import cld_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [POS_W-1:0]    position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [WHERE_W-1:0]  where,
    output logic [COUNT_W-1:0]  count
);

    mem_req_t            req;
    logic [VALUE_W-1:0]  rdata;
    logic                idle;
    logic                res_valid;
    logic                res_take;
    logic [STATUS_W-1:0] res_status;
    logic [WHERE_W-1:0]  res_where;
    logic [COUNT_W-1:0]  res_count;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [WHERE_W-1:0]  where_reg;
    logic [COUNT_W-1:0]  count_reg;

    assign in_ready = idle;
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    cld_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && in_ready),
        .action     (action),
        .value      (value),
        .position   (position),
        .idle       (idle),
        .req        (req),
        .rdata      (rdata),
        .res_take   (res_take),
        .res_valid  (res_valid),
        .res_status (res_status),
        .res_where  (res_where),
        .res_count  (res_count)
    );

    cld_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            status_reg <= res_status;
            where_reg  <= res_where;
            count_reg  <= res_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign where     = where_reg;
    assign count     = count_reg;

endmodule

// ----- rtl/cld_store.sv -----
// entry store: one write port and one read port with registered read data
// depends on cld_pkg
`timescale 1ns / 1ps

module cld_store
    import cld_pkg::*;
(
    input  logic               clk,
    input  mem_req_t           req,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, data in the next cycle
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cld_ctrl.sv -----
// sequencer: append, and search and compaction over the entry store, one entry a cycle
// depends on cld_pkg; drives the cld_store port
`timescale 1ns / 1ps

module cld_ctrl
    import cld_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ACTION_W-1:0] action,
    input  logic [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]    position,
    output logic                idle,
    output mem_req_t            req,
    input  logic [VALUE_W-1:0]  rdata,
    input  logic                res_take,
    output logic                res_valid,
    output logic [STATUS_W-1:0] res_status,
    output logic [WHERE_W-1:0]  res_where,
    output logic [COUNT_W-1:0]  res_count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]          state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [CNT_W-1:0]    rptr_reg,   rptr_next;
    logic [ADDR_W-1:0]   wptr_reg,   wptr_next;
    logic [ADDR_W-1:0]   cidx_reg,   cidx_next;
    logic [ADDR_W-1:0]   where_reg,  where_next;
    logic                pend_reg,   pend_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  key_reg,    key_next;

    logic rd_en;
    logic hit;
    logic full;
    logic pos_ok;

    // compare unit and bounds checks
    assign rd_en  = (rptr_reg < count_reg);
    assign hit    = pend_reg && (rdata == key_reg);
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign pos_ok = (32'(position) < 32'(count_reg));

    // next state and store access
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rptr_next   = rptr_reg;
        wptr_next   = wptr_reg;
        cidx_next   = cidx_reg;
        where_next  = where_reg;
        pend_next   = 1'b0;
        status_next = status_reg;
        key_next    = key_reg;
        req         = '0;
        req.raddr   = rptr_reg[ADDR_W-1:0];
        req.waddr   = wptr_reg;
        req.wdata   = rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next = value;
                    case (action)
                        ACT_APPEND:
                        begin
                            state_next = S_RESULT;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                req.we      = 1'b1;
                                req.waddr   = count_reg[ADDR_W-1:0];
                                req.wdata   = value;
                                where_next  = count_reg[ADDR_W-1:0];
                                count_next  = count_reg + 1'b1;
                                status_next = ST_DONE;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (pos_ok)
                            begin
                                state_next = S_SHIFT;
                                wptr_next  = ADDR_W'(position);
                                where_next = ADDR_W'(position);
                                rptr_next  = CNT_W'(position) + 1'b1;
                            end
                            else
                            begin
                                state_next  = S_RESULT;
                                status_next = ST_BADPOS;
                            end
                        end
                        ACT_FIND:
                        begin
                            state_next = S_SEARCH;
                            rptr_next  = '0;
                        end
                        default:
                        begin
                            state_next  = S_RESULT;
                            status_next = ST_BADPOS;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    // stop reading and start compacting at the match
                    state_next = S_SHIFT;
                    wptr_next  = cidx_reg;
                    where_next = cidx_reg;
                    rptr_next  = CNT_W'(cidx_reg) + 1'b1;
                end
                else if (rd_en)
                begin
                    req.re    = 1'b1;
                    cidx_next = rptr_reg[ADDR_W-1:0];
                    rptr_next = rptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next  = S_RESULT;
                    status_next = ST_NOTFOUND;
                end
            end

            S_SHIFT:
            begin
                // read the next entry while writing the one fetched last cycle
                if (rd_en)
                begin
                    req.re    = 1'b1;
                    rptr_next = rptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    req.we    = 1'b1;
                    wptr_next = wptr_reg + 1'b1;
                end
                if (!rd_en && !pend_reg)
                begin
                    state_next  = S_RESULT;
                    count_next  = count_reg - 1'b1;
                    status_next = ST_DONE;
                end
            end

            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rptr_reg   <= rptr_next;
        wptr_reg   <= wptr_next;
        cidx_reg   <= cidx_next;
        where_reg  <= where_next;
        status_reg <= status_next;
        key_reg    <= key_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESULT);
    assign res_status = status_reg;
    assign res_where  = (status_reg == ST_DONE) ? WHERE_W'(where_reg) : '0;
    assign res_count  = COUNT_W'(count_reg);

endmodule

// ----- rtl/cld_checker.sv -----
// port-level checks for the compacting list and the bind that attaches them
// depends on cld_pkg and compacting_list_with_delete_core
`timescale 1ns / 1ps

module cld_checker
    import cld_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [WHERE_W-1:0]  where,
    input logic [COUNT_W-1:0]  count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(where)
            && $stable(count))
        else $error("result changed while stalled");

    // busy right after taking a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("took a second request while busy");

    // a refused request reports position zero
    a_where_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DONE) |-> where == '0)
        else $error("nonzero position on a refused request");

    // full only at capacity, count never beyond it
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= COUNT_W'(DEPTH))
            && ((status != ST_FULL) || (count == COUNT_W'(DEPTH))))
        else $error("count out of range or full below capacity");

endmodule

bind compacting_list_with_delete_core cld_checker u_cld_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .where     (where),
    .count     (count)
);

// ----- tb/sv/tb.sv -----
// self-checking testbench for compacting_list_with_delete_core
// depends on cld_pkg and the core; drives requests, predicts each result and compares
`timescale 1ns / 1ps

module tb;
    import cld_pkg::*;

    // action code with no meaning, the block refuses it
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 800;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WHERE_W-1:0]  where;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    // shadow copy of the list plus the queue of results still owed by the block
    class list_shadow;
        logic signed [VALUE_W-1:0] entries [DEPTH];
        int                        fill;
        list_result_t              pending_results [$];
        int                        mismatch_count;
        int                        results_seen;

        function new();
            fill           = 0;
            mismatch_count = 0;
            results_seen   = 0;
        endfunction

        // close the gap left by a removed entry
        function void drop_entry(int idx);
            for (int i = idx; i < fill - 1; i++)
                entries[i] = entries[i + 1];
            fill--;
        endfunction

        // apply one accepted request and queue the result it must give
        function void note_request(logic [ACTION_W-1:0] act,
                                   logic signed [VALUE_W-1:0] val,
                                   logic [POS_W-1:0] pos);
            list_result_t res;
            res.status = ST_BADPOS;
            res.where  = '0;
            case (act)
                ACT_APPEND:
                    if (fill >= DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        entries[fill] = val;
                        res.where     = WHERE_W'(fill);
                        fill++;
                        res.status    = ST_DONE;
                    end
                ACT_REMOVE:
                    if (int'(pos) < fill)
                    begin
                        drop_entry(int'(pos));
                        res.where  = pos;
                        res.status = ST_DONE;
                    end
                ACT_FIND:
                begin
                    res.status = ST_NOTFOUND;
                    for (int i = 0; i < fill; i++)
                    begin
                        if (entries[i] == val)
                        begin
                            drop_entry(i);
                            res.where  = WHERE_W'(i);
                            res.status = ST_DONE;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            res.count = COUNT_W'(fill);
            pending_results.push_back(res);
        endfunction

        // compare one result from the block with the oldest one owed
        function void check_result(logic [STATUS_W-1:0] st, logic [WHERE_W-1:0] wh,
                                   logic [COUNT_W-1:0] cnt);
            list_result_t exp_res;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected result: status %0d where %0d count %0d",
                             $realtime, st, wh, cnt);
                return;
            end
            exp_res = pending_results.pop_front();
            if (st !== exp_res.status || wh !== exp_res.where || cnt !== exp_res.count)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $realtime, results_seen, exp_res.status, exp_res.where,
                             exp_res.count, st, wh, cnt);
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n    = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [ACTION_W-1:0]        action   = ACT_APPEND;
    logic signed [VALUE_W-1:0]  value    = '0;
    logic [POS_W-1:0]           position = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic [WHERE_W-1:0]         where;
    logic [COUNT_W-1:0]         count;
    logic                       rx_hold   = 1'b0;

    list_shadow sb = new();

    compacting_list_with_delete_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .where     (where),
        .count     (count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle cycles before the next item, with runs of back-to-back traffic
    function automatic int draw_gap(ref int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            quiet = $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // value mix: a small pool for duplicates, the extremes, and full random words
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1: return int'($urandom_range(0, 7)) - 4;
            2:
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            default: return $urandom;
        endcase
    endfunction

    int tx_quiet = 0;

    // offer one request and hold it until the block takes it
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic signed [VALUE_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        position <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(act, val, pos);
    endtask

    // random request shaped by the current list: mostly legal work, some refusals and noise
    task automatic pick_request(input int grow_pct,
                                output logic [ACTION_W-1:0] act,
                                output logic signed [VALUE_W-1:0] val,
                                output logic [POS_W-1:0] pos);
        int r;
        r   = $urandom_range(0, 99);
        val = $urandom;
        pos = POS_W'($urandom_range(0, 15));
        if (r < 3)
            act = ACT_UNUSED;
        else if (r < grow_pct)
        begin
            act = ACT_APPEND;
            val = pick_value();
        end
        else if (r % 2 == 0)
        begin
            act = ACT_REMOVE;
            if (sb.fill > 0 && $urandom_range(0, 99) < 85)
                pos = POS_W'($urandom_range(0, sb.fill - 1));
        end
        else
        begin
            act = ACT_FIND;
            if (sb.fill > 0 && $urandom_range(0, 99) < 75)
                val = sb.entries[$urandom_range(0, sb.fill - 1)];
            else
                val = pick_value();
        end
    endtask

    // result side: random stalls, plus the long hold-off below
    initial
    begin
        int rx_gap;
        int rx_quiet;
        rx_gap   = 0;
        rx_quiet = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_valid && out_ready)
                begin
                    sb.check_result(status, where, count);
                    rx_gap = draw_gap(rx_quiet);
                end
                else if (rx_gap > 0)
                    rx_gap--;
                out_ready <= (rx_gap == 0) && !rx_hold;
            end
        end
    end

    // long receiver stall so the block backs up and stops taking new requests
    initial
    begin
        do
            @(posedge clk);
        while (sb.results_seen < 150);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // reset, directed requests, random requests, drain
    initial
    begin
        logic [ACTION_W-1:0]       act;
        logic signed [VALUE_W-1:0] val;
        logic [POS_W-1:0]          pos;
        int                        grow_pct;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // removal and search on an empty list
        send_request(ACT_REMOVE, 32'sh0, 4'd0);
        send_request(ACT_FIND, 32'sh0, 4'd0);

        // fill to capacity with extremes, alternating bits and a duplicate
        send_request(ACT_APPEND, 32'sh8000_0000, 4'd15);
        send_request(ACT_APPEND, 32'sh7fff_ffff, 4'd0);
        send_request(ACT_APPEND, 32'sh0, 4'd0);
        send_request(ACT_APPEND, -32'sd1, 4'd0);
        send_request(ACT_APPEND, 32'sd5, 4'd0);
        send_request(ACT_APPEND, 32'sh5555_5555, 4'd10);
        send_request(ACT_APPEND, 32'shaaaa_aaaa, 4'd5);
        send_request(ACT_APPEND, 32'sd5, 4'd0);
        repeat (8) send_request(ACT_APPEND, $urandom, POS_W'($urandom_range(0, 15)));

        // full list, meaningless action, removal at both ends
        send_request(ACT_APPEND, 32'sd7, 4'd0);
        send_request(ACT_UNUSED, 32'sd5, 4'd7);
        send_request(ACT_REMOVE, 32'sh0, 4'd15);
        send_request(ACT_REMOVE, 32'sh0, 4'd0);

        // first of two matches, a miss, and a position past the count
        send_request(ACT_FIND, 32'sd5, 4'd0);
        send_request(ACT_FIND, 32'sh1234_5678, 4'd0);
        send_request(ACT_REMOVE, 32'sh0, 4'd14);

        // random traffic with phases that grow, hold or shrink the list
        grow_pct = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 40 == 0)
                case ($urandom_range(0, 2))
                    0: grow_pct = 20;
                    1: grow_pct = 50;
                    default: grow_pct = 85;
                endcase
            pick_request(grow_pct, act, val, pos);
            send_request(act, val, pos);
        end
        in_valid <= 1'b0;

        // wait for every owed result, then let stray output show up
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
